// File: sv/gpio_psc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// GPIO port set/clear registers: shared types and constants
// Word map, register selection codes, alias kinds and mask helpers.
// ----------------------------------------------------------------------------
package gpio_psc_pkg;

    localparam int          WORD_W           = 32;
    localparam int          IDX_W            = 7;
    localparam int          MAX_PINS         = 32;
    localparam int          DRIVE_PINS       = 16;
    localparam int          DRIVE_LOW_BYTE   = 'h130;
    localparam int          DRIVE_HIGH_BYTE  = 'h140;
    localparam logic [1:0]  DRIVE_FIELD_MASK = 2'd3;

    localparam logic [IDX_W-1:0] IDX_INL     = 7'd0;
    localparam logic [IDX_W-1:0] IDX_INT     = 7'd4;
    localparam logic [IDX_W-1:0] IDX_MSK     = 7'd8;
    localparam logic [IDX_W-1:0] IDX_PAT1    = 7'd12;
    localparam logic [IDX_W-1:0] IDX_PAT0    = 7'd16;
    localparam logic [IDX_W-1:0] IDX_PEN     = 7'd28;
    localparam logic [IDX_W-1:0] IDX_DRV_LO  = IDX_W'(DRIVE_LOW_BYTE / 4);
    localparam logic [IDX_W-1:0] IDX_DRV_HI  = IDX_W'(DRIVE_HIGH_BYTE / 4);

    typedef enum logic [1:0] {
        KIND_PLAIN = 2'd0,
        KIND_SET   = 2'd1,
        KIND_CLR   = 2'd2
    } alias_kind_t;

    typedef enum logic [3:0] {
        SEL_NONE,
        SEL_INL,
        SEL_INT,
        SEL_MSK,
        SEL_PAT1,
        SEL_PAT0,
        SEL_PEN,
        SEL_DRV_LO,
        SEL_DRV_HI
    } reg_sel_t;

    function automatic logic [WORD_W-1:0] pin_mask_f(input int count);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int p = 0; p < MAX_PINS; p++)
        begin
            if (p < count)
            begin
                m[p] = 1'b1;
            end
        end
        return m;
    endfunction

    function automatic logic [WORD_W-1:0] drive_mask_f(input int first, input int count);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int p = 0; p < DRIVE_PINS; p++)
        begin
            if (first + p < count)
            begin
                m[2*p +: 2] = DRIVE_FIELD_MASK;
            end
        end
        return m;
    endfunction

    function automatic logic alias_in_group(input logic [IDX_W-1:0] idx,
                                            input logic [IDX_W-1:0] base);
        return (idx[IDX_W-1:2] == base[IDX_W-1:2]) && (idx[1:0] != 2'd3);
    endfunction

    function automatic reg_sel_t decode_sel(input logic [IDX_W-1:0] idx);
        reg_sel_t sel;
        priority if (idx == IDX_INL)
            sel = SEL_INL;
        else if (alias_in_group(idx, IDX_INT))
            sel = SEL_INT;
        else if (alias_in_group(idx, IDX_MSK))
            sel = SEL_MSK;
        else if (alias_in_group(idx, IDX_PAT1))
            sel = SEL_PAT1;
        else if (alias_in_group(idx, IDX_PAT0))
            sel = SEL_PAT0;
        else if (alias_in_group(idx, IDX_PEN))
            sel = SEL_PEN;
        else if (idx == IDX_DRV_LO)
            sel = SEL_DRV_LO;
        else if (idx == IDX_DRV_HI)
            sel = SEL_DRV_HI;
        else
            sel = SEL_NONE;
        return sel;
    endfunction

endpackage
`default_nettype wire

// File: sv/gpio_psc_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// GPIO port set/clear registers: bus access channel
// Valid/ready channel carrying one register access per item.
// ----------------------------------------------------------------------------
interface gpio_psc_req_if;

    logic        valid;
    logic        ready;
    logic        req_type;
    logic [6:0]  reg_word_index;
    logic [31:0] write_data;
    logic [31:0] pin_levels;

    modport source (
        output valid,
        input  ready,
        output req_type,
        output reg_word_index,
        output write_data,
        output pin_levels
    );

    modport sink (
        input  valid,
        output ready,
        input  req_type,
        input  reg_word_index,
        input  write_data,
        input  pin_levels
    );

endinterface
`default_nettype wire

// File: sv/gpio_psc_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// GPIO port set/clear registers: result channel
// Valid/ready channel carrying read data, error and pin decode per item.
// ----------------------------------------------------------------------------
interface gpio_psc_rsp_if;

    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        access_error;
    logic [31:0] pin_output_enable;
    logic [31:0] pin_output_level;
    logic [31:0] pin_irq_enable;

    modport source (
        output valid,
        input  ready,
        output read_data,
        output access_error,
        output pin_output_enable,
        output pin_output_level,
        output pin_irq_enable
    );

    modport sink (
        input  valid,
        output ready,
        input  read_data,
        input  access_error,
        input  pin_output_enable,
        input  pin_output_level,
        input  pin_irq_enable
    );

endinterface
`default_nettype wire

// File: sv/gpio_port_set_clear_regs_unit.sv
// An accepted access passes through the input register, then the result register. Throughput:
// one access per cycle absent stalls; the input register refills as the result register
// drains. Back pressure from the result side stalls the input register only when both are
// full. Reset clears all configuration words to zero and empties both pipeline registers.
`default_nettype none
// ----------------------------------------------------------------------------
// GPIO port set/clear registers
// 32-pin GPIO register file with set/clear aliases and per-pin mode decode.
// ----------------------------------------------------------------------------
module gpio_port_set_clear_regs_unit #(
    parameter int PIN_COUNT = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    gpio_psc_req_if.sink          req,
    gpio_psc_rsp_if.source        rsp
);

    import gpio_psc_pkg::*;

    localparam logic [WORD_W-1:0] PIN_MASK    = pin_mask_f(PIN_COUNT);
    localparam logic [WORD_W-1:0] DRV_LO_MASK = drive_mask_f(0, PIN_COUNT);
    localparam logic [WORD_W-1:0] DRV_HI_MASK = drive_mask_f(DRIVE_PINS, PIN_COUNT);

    logic              in_valid_reg;
    logic              in_write_reg;
    logic [IDX_W-1:0]  in_idx_reg;
    logic [WORD_W-1:0] in_wdata_reg;
    logic [WORD_W-1:0] in_levels_reg;

    logic [WORD_W-1:0] int_reg,    int_next;
    logic [WORD_W-1:0] msk_reg,    msk_next;
    logic [WORD_W-1:0] pat1_reg,   pat1_next;
    logic [WORD_W-1:0] pat0_reg,   pat0_next;
    logic [WORD_W-1:0] pen_reg,    pen_next;
    logic [WORD_W-1:0] drv_lo_reg, drv_lo_next;
    logic [WORD_W-1:0] drv_hi_reg, drv_hi_next;

    logic              out_valid_reg;
    logic [WORD_W-1:0] rdata_reg,  rdata_next;
    logic              err_reg,    err_next;
    logic [WORD_W-1:0] oe_reg;
    logic [WORD_W-1:0] olvl_reg;
    logic [WORD_W-1:0] irq_reg;

    logic              advance;
    logic              in_take;
    reg_sel_t          sel;
    alias_kind_t       kind;
    logic [WORD_W-1:0] keep;
    logic [WORD_W-1:0] cur;
    logic [WORD_W-1:0] wmasked;
    logic [WORD_W-1:0] upd;
    logic              do_write;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign in_take   = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_write_reg  <= req.req_type;
            in_idx_reg    <= req.reg_word_index;
            in_wdata_reg  <= req.write_data;
            in_levels_reg <= req.pin_levels;
        end
    end

    always_comb
    begin
        sel  = decode_sel(in_idx_reg);
        kind = alias_kind_t'(in_idx_reg[1:0]);
        unique case (sel)
            SEL_DRV_LO: keep = DRV_LO_MASK;
            SEL_DRV_HI: keep = DRV_HI_MASK;
            default:    keep = PIN_MASK;
        endcase
        unique case (sel)
            SEL_INT:    cur = int_reg;
            SEL_MSK:    cur = msk_reg;
            SEL_PAT1:   cur = pat1_reg;
            SEL_PAT0:   cur = pat0_reg;
            SEL_PEN:    cur = pen_reg;
            SEL_DRV_LO: cur = drv_lo_reg;
            SEL_DRV_HI: cur = drv_hi_reg;
            default:    cur = '0;
        endcase
        wmasked = in_wdata_reg & keep;
        unique case (kind)
            KIND_PLAIN: upd = wmasked;
            KIND_SET:   upd = cur | wmasked;
            KIND_CLR:   upd = cur & ~wmasked;
            default:    upd = cur;
        endcase

        do_write = advance && in_write_reg;

        int_next    = int_reg;
        msk_next    = msk_reg;
        pat1_next   = pat1_reg;
        pat0_next   = pat0_reg;
        pen_next    = pen_reg;
        drv_lo_next = drv_lo_reg;
        drv_hi_next = drv_hi_reg;
        rdata_next  = '0;
        err_next    = 1'b0;

        unique case (sel)
            SEL_NONE:
            begin
                err_next = 1'b1;
            end
            SEL_INL:
            begin
                if (in_write_reg)
                    err_next = 1'b1;
                else
                    rdata_next = in_levels_reg & PIN_MASK;
            end
            default:
            begin
                if (!in_write_reg)
                    rdata_next = cur;
            end
        endcase

        if (do_write)
        begin
            unique case (sel)
                SEL_INT:    int_next    = upd;
                SEL_MSK:    msk_next    = upd;
                SEL_PAT1:   pat1_next   = upd;
                SEL_PAT0:   pat0_next   = upd;
                SEL_PEN:    pen_next    = upd;
                SEL_DRV_LO: drv_lo_next = upd;
                SEL_DRV_HI: drv_hi_next = upd;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            int_reg    <= '0;
            msk_reg    <= '0;
            pat1_reg   <= '0;
            pat0_reg   <= '0;
            pen_reg    <= '0;
            drv_lo_reg <= '0;
            drv_hi_reg <= '0;
        end
        else
        begin
            int_reg    <= int_next;
            msk_reg    <= msk_next;
            pat1_reg   <= pat1_next;
            pat0_reg   <= pat0_next;
            pen_reg    <= pen_next;
            drv_lo_reg <= drv_lo_next;
            drv_hi_reg <= drv_hi_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rdata_reg <= rdata_next;
            err_reg   <= err_next;
            oe_reg    <= ~int_next & msk_next & ~pat1_next & PIN_MASK;
            olvl_reg  <= pat0_next & PIN_MASK;
            irq_reg   <= int_next & ~msk_next & PIN_MASK;
        end
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.read_data         = rdata_reg;
    assign rsp.access_error      = err_reg;
    assign rsp.pin_output_enable = oe_reg;
    assign rsp.pin_output_level  = olvl_reg;
    assign rsp.pin_irq_enable    = irq_reg;

    a_err_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.access_error |-> rsp.read_data == '0)
        else $error("error item carries read data");

    a_modes_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.pin_output_enable & rsp.pin_irq_enable) == '0)
        else $error("pin both output and interrupt");

    a_unused_pins_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> ((rsp.pin_output_enable | rsp.pin_output_level
                        | rsp.pin_irq_enable) & ~PIN_MASK) == '0)
        else $error("pin above count active");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && in_write_reg) |=> $stable(int_reg) && $stable(msk_reg)
            && $stable(pat1_reg) && $stable(pat0_reg) && $stable(pen_reg)
            && $stable(drv_lo_reg) && $stable(drv_hi_reg))
        else $error("config word changed without write");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_idx_reg))
        else $error("input register lost item under stall");

endmodule
`default_nettype wire
